@@ rtl/largest_inscribed_rect_after_rotation_defines.svh @@
// assertion macros for the inscribed rectangle block
// used by the checker module only
`ifndef LARGEST_INSCRIBED_RECT_AFTER_ROTATION_DEFINES_SVH
`define LARGEST_INSCRIBED_RECT_AFTER_ROTATION_DEFINES_SVH

// implication checked on every edge outside reset
`define LIR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lir_pkg.sv @@
// shared constants, types and tables for the inscribed rectangle block
// no dependencies
`timescale 1ns / 1ps

package lir_pkg;

    localparam int DimW       = 13;
    localparam int AngW       = 19;
    localparam int MaxDim     = 4096;
    localparam int FracBits   = 16;
    localparam int CordicIter = 30;
    localparam int CordicW    = 34;
    localparam int TrigW      = FracBits + 1;
    localparam int BbW        = DimW + TrigW + 1;
    localparam int ProdW      = DimW + 2 * TrigW;
    localparam int DenW       = TrigW + 1;
    localparam int YW         = ProdW;
    localparam int DivSteps   = ProdW;
    // cordic: load stage, one stage per iteration, rounding stage
    localparam int LatCordic  = CordicIter + 2;
    // edges from the accepting edge to the edge that raises done
    localparam int Latency    = 3 + LatCordic + 2 + (DivSteps + 1);

    localparam logic [AngW-1:0] AngHalfPi = AngW'(102944);
    localparam logic [AngW-1:0] AngPi     = AngW'(205888);
    localparam logic signed [CordicW-1:0] CordicGain = CordicW'(32'h26DD3B6A);

    typedef logic signed [CordicW-1:0] cordic_t;

    function automatic cordic_t atan_lut(input int i);
        cordic_t r;
        r = '0;
        case (i)
            0: r = CordicW'(32'h3243F6A8);
            1: r = CordicW'(32'h1DAC6705);
            2: r = CordicW'(32'h0FADBAFC);
            3: r = CordicW'(32'h07F56EA6);
            4: r = CordicW'(32'h03FEAB76);
            5: r = CordicW'(32'h01FFD55B);
            6: r = CordicW'(32'h00FFFAAA);
            7: r = CordicW'(32'h007FFF55);
            8: r = CordicW'(32'h003FFFEA);
            9: r = CordicW'(32'h001FFFFD);
            10: r = CordicW'(32'h000FFFFF);
            11: r = CordicW'(32'h0007FFFF);
            12: r = CordicW'(32'h0003FFFF);
            13: r = CordicW'(32'h0001FFFF);
            14: r = CordicW'(32'h0000FFFF);
            15: r = CordicW'(32'h00007FFF);
            16: r = CordicW'(32'h00003FFF);
            17: r = CordicW'(32'h00001FFF);
            18: r = CordicW'(32'h00000FFF);
            19: r = CordicW'(32'h000007FF);
            20: r = CordicW'(32'h000003FF);
            21: r = CordicW'(32'h000001FF);
            22: r = CordicW'(32'h000000FF);
            23: r = CordicW'(32'h0000007F);
            24: r = CordicW'(32'h0000003F);
            25: r = CordicW'(32'h0000001F);
            26: r = CordicW'(32'h0000000F);
            27: r = CordicW'(32'h00000008);
            28: r = CordicW'(32'h00000004);
            29: r = CordicW'(32'h00000002);
            default: r = '0;
        endcase
        return r;
    endfunction

    // operands carried alongside the cordic
    typedef struct packed {
        logic [DimW-1:0] h;
        logic [DimW-1:0] w;
    } dims_t;

    // operands carried alongside the divider
    typedef struct packed {
        logic [BbW-1:0] bb_w;
        logic [BbW-1:0] bb_h;
    } bbox_t;

endpackage

@@ rtl/largest_inscribed_rect_after_rotation.sv @@
// top level of the inscribed rectangle block: fold, cordic, products, divide, finish
// depends on lir_pkg, lir_cordic and lir_divider
`timescale 1ns / 1ps

// Usage: present img_height, img_width and rot_angle (Q3.16 radians) with start
// high; the transaction is taken at a rising edge where busy is low. busy is
// tied low: a new transaction may enter on every cycle.
// Each transaction gives one result, crop_width and crop_height, shown for one
// cycle with done high. Between the accepting edge and done (lir_pkg::Latency)
// lie 3 fold stages, 32 cordic stages (load, 30 iterations, rounding), 2
// product stages, 48 divider stages (load, 47 quotient bits), then the output
// register.
// Throughput is one transaction per cycle; the latency is set by the cordic
// iteration pipeline and the one-bit-per-stage divider.
// Results leave in acceptance order. The receiver cannot stall, so there is
// no back-pressure path.
// Reset (rst_n low, asynchronous) clears all valid bits; transactions in
// flight are dropped and no result appears until new ones are accepted.

module largest_inscribed_rect_after_rotation (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lir_pkg::DimW-1:0]    img_height,
    input  logic [lir_pkg::DimW-1:0]    img_width,
    input  logic [lir_pkg::AngW-1:0]    rot_angle,
    output logic                        done,
    output logic [lir_pkg::DimW-1:0]    crop_width,
    output logic [lir_pkg::DimW-1:0]    crop_height
);

    localparam int AW = lir_pkg::AngW;

    assign busy = 1'b0;

    // stage a: capture and first conditional subtract of 2*pi
    logic            va_reg;
    logic [AW-1:0]   ang_a_reg;
    lir_pkg::dims_t  dims_a_reg;
    logic [AW:0]     twopi;
    assign twopi = {lir_pkg::AngPi, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        ang_a_reg  <= ({1'b0, rot_angle} >= twopi) ? AW'({1'b0, rot_angle} - twopi)
                                                    : rot_angle;
        dims_a_reg <= '{h: img_height, w: img_width};
    end

    // stage b: remainder modulo pi (input below 2*pi now)
    logic            vb_reg;
    logic [AW-1:0]   r_b_reg;
    lir_pkg::dims_t  dims_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        r_b_reg    <= (ang_a_reg >= lir_pkg::AngPi) ? ang_a_reg - lir_pkg::AngPi : ang_a_reg;
        dims_b_reg <= dims_a_reg;
    end

    // stage c: fold into the first quadrant
    logic            vc_reg;
    logic [AW-1:0]   alpha_reg;
    lir_pkg::dims_t  dims_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        alpha_reg  <= (r_b_reg < lir_pkg::AngHalfPi) ? r_b_reg : lir_pkg::AngPi - r_b_reg;
        dims_c_reg <= dims_b_reg;
    end

    // sine and cosine
    logic                          vt;
    logic [lir_pkg::TrigW-1:0]     cos_q;
    logic [lir_pkg::TrigW-1:0]     sin_q;
    lir_pkg::dims_t                dims_t_w;

    lir_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .alpha     (alpha_reg),
        .in_dims   (dims_c_reg),
        .out_valid (vt),
        .cos_q     (cos_q),
        .sin_q     (sin_q),
        .out_dims  (dims_t_w)
    );

    // stage p1: four dimension products, cos*sin, longer side, divisor
    localparam int PW  = lir_pkg::DimW + lir_pkg::TrigW;
    localparam int CSW = 2 * lir_pkg::TrigW;

    logic                        vp1_reg;
    logic [PW-1:0]               wc_reg, hs_reg, ws_reg, hc_reg;
    logic [CSW-1:0]              cs_reg;
    logic [lir_pkg::DimW-1:0]    len_reg;
    logic [lir_pkg::DenW-1:0]    den_p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp1_reg <= 1'b0;
        else
            vp1_reg <= vt;
    end

    always_ff @(posedge clk)
    begin
        wc_reg     <= PW'(dims_t_w.w) * PW'(cos_q);
        hs_reg     <= PW'(dims_t_w.h) * PW'(sin_q);
        ws_reg     <= PW'(dims_t_w.w) * PW'(sin_q);
        hc_reg     <= PW'(dims_t_w.h) * PW'(cos_q);
        cs_reg     <= CSW'(cos_q) * CSW'(sin_q);
        len_reg    <= (dims_t_w.w < dims_t_w.h) ? dims_t_w.h : dims_t_w.w;
        den_p1_reg <= lir_pkg::DenW'(cos_q) + lir_pkg::DenW'(sin_q);
    end

    // stage p2: bounding box sums and len*cos*sin
    logic                        vp2_reg;
    lir_pkg::bbox_t              bb_p2_reg;
    logic [lir_pkg::ProdW-1:0]   num_reg;
    logic [lir_pkg::DenW-1:0]    den_p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp2_reg <= 1'b0;
        else
            vp2_reg <= vp1_reg;
    end

    always_ff @(posedge clk)
    begin
        bb_p2_reg.bb_w <= lir_pkg::BbW'(wc_reg) + lir_pkg::BbW'(hs_reg);
        bb_p2_reg.bb_h <= lir_pkg::BbW'(ws_reg) + lir_pkg::BbW'(hc_reg);
        num_reg        <= lir_pkg::ProdW'(len_reg) * lir_pkg::ProdW'(cs_reg);
        den_p2_reg     <= den_p1_reg;
    end

    // y = len*cos*sin / (cos+sin)
    logic                        vd;
    logic [lir_pkg::YW-1:0]      y_q;
    lir_pkg::bbox_t              bb_d;

    lir_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vp2_reg),
        .num       (num_reg),
        .den       (den_p2_reg),
        .in_bb     (bb_p2_reg),
        .out_valid (vd),
        .quot      (y_q),
        .out_bb    (bb_d)
    );

    // finish: subtract 2y, truncate, clamp
    localparam int FW = lir_pkg::YW + 2;

    function automatic logic [lir_pkg::DimW-1:0] finish(
        input logic [lir_pkg::BbW-1:0] bb,
        input logic [lir_pkg::YW-1:0]  y
    );
        logic [FW-1:0] two_y;
        logic [FW-1:0] diff;
        logic [FW-1:0] v;
        two_y = {1'b0, y, 1'b0};
        diff  = FW'(bb) - two_y;
        v     = diff >> lir_pkg::FracBits;
        if (FW'(bb) <= two_y)
            return '0;
        else if (v > FW'(lir_pkg::MaxDim))
            return lir_pkg::DimW'(lir_pkg::MaxDim);
        else
            return v[lir_pkg::DimW-1:0];
    endfunction

    logic                        done_reg;
    logic [lir_pkg::DimW-1:0]    cw_reg;
    logic [lir_pkg::DimW-1:0]    ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vd;
    end

    always_ff @(posedge clk)
    begin
        cw_reg <= finish(bb_d.bb_w, y_q);
        ch_reg <= finish(bb_d.bb_h, y_q);
    end

    assign done        = done_reg;
    assign crop_width  = cw_reg;
    assign crop_height = ch_reg;

endmodule

@@ rtl/lir_cordic.sv @@
// pipelined rotation-mode cordic, one iteration per stage, sin and cos out
// depends on lir_pkg
`timescale 1ns / 1ps

module lir_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [lir_pkg::AngW-1:0]      alpha,
    input  lir_pkg::dims_t                in_dims,
    output logic                          out_valid,
    output logic [lir_pkg::TrigW-1:0]     cos_q,
    output logic [lir_pkg::TrigW-1:0]     sin_q,
    output lir_pkg::dims_t                out_dims
);

    localparam int N = lir_pkg::CordicIter;

    lir_pkg::cordic_t x_reg [0:N];
    lir_pkg::cordic_t y_reg [0:N];
    lir_pkg::cordic_t z_reg [0:N];
    lir_pkg::dims_t   d_reg [0:N];
    logic [N:0]       v_reg;

    // stage 0 loads the start vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= lir_pkg::CordicGain;
        y_reg[0] <= '0;
        z_reg[0] <= lir_pkg::cordic_t'({alpha, 14'd0});
        d_reg[0] <= in_dims;
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][lir_pkg::CordicW-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - lir_pkg::atan_lut(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + lir_pkg::atan_lut(i);
            end
            d_reg[i+1] <= d_reg[i];
        end
    end

    // round half up to q16 and clamp to 0..1
    function automatic logic [lir_pkg::TrigW-1:0] to_frac(input lir_pkg::cordic_t v);
        lir_pkg::cordic_t r;
        r = (v + lir_pkg::cordic_t'(1 << (29 - lir_pkg::FracBits))) >>> (30 - lir_pkg::FracBits);
        if (r[lir_pkg::CordicW-1])
            return '0;
        else if (r > lir_pkg::cordic_t'(1 << lir_pkg::FracBits))
            return lir_pkg::TrigW'(1 << lir_pkg::FracBits);
        else
            return r[lir_pkg::TrigW-1:0];
    endfunction

    logic                       ov_reg;
    logic [lir_pkg::TrigW-1:0]  c_reg;
    logic [lir_pkg::TrigW-1:0]  s_reg;
    lir_pkg::dims_t             od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        c_reg  <= to_frac(x_reg[N]);
        s_reg  <= to_frac(y_reg[N]);
        od_reg <= d_reg[N];
    end

    assign out_valid = ov_reg;
    assign cos_q     = c_reg;
    assign sin_q     = s_reg;
    assign out_dims  = od_reg;

endmodule

@@ rtl/lir_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on lir_pkg
`timescale 1ns / 1ps

module lir_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [lir_pkg::ProdW-1:0]   num,
    input  logic [lir_pkg::DenW-1:0]    den,
    input  lir_pkg::bbox_t              in_bb,
    output logic                        out_valid,
    output logic [lir_pkg::YW-1:0]      quot,
    output lir_pkg::bbox_t              out_bb
);

    localparam int N  = lir_pkg::DivSteps;
    localparam int RW = lir_pkg::DenW + 1;

    logic [lir_pkg::ProdW-1:0] n_reg [0:N];
    logic [RW-1:0]             r_reg [0:N];
    logic [lir_pkg::DenW-1:0]  d_reg [0:N];
    lir_pkg::bbox_t            b_reg [0:N];
    logic [N:0]                v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        n_reg[0] <= num;
        r_reg[0] <= '0;
        d_reg[0] <= den;
        b_reg[0] <= in_bb;
    end

    // shift in one numerator bit, subtract if it fits; quotient bits fill n
    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [RW-1:0] sh;
        logic [RW:0]   diff;
        assign sh   = {r_reg[i][RW-2:0], n_reg[i][lir_pkg::ProdW-1]};
        assign diff = {1'b0, sh} - {2'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            if (!diff[RW])
            begin
                r_reg[i+1] <= diff[RW-1:0];
                n_reg[i+1] <= {n_reg[i][lir_pkg::ProdW-2:0], 1'b1};
            end
            else
            begin
                r_reg[i+1] <= sh;
                n_reg[i+1] <= {n_reg[i][lir_pkg::ProdW-2:0], 1'b0};
            end
            d_reg[i+1] <= d_reg[i];
            b_reg[i+1] <= b_reg[i];
        end
    end

    assign out_valid = v_reg[N];
    assign quot      = (d_reg[N] == '0) ? '0 : n_reg[N];
    assign out_bb    = b_reg[N];

endmodule

@@ rtl/lir_checker.sv @@
// port-level checks for the inscribed rectangle block, bound to the top level
// depends on lir_pkg and the defines header
`timescale 1ns / 1ps
`include "largest_inscribed_rect_after_rotation_defines.svh"

module lir_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [lir_pkg::DimW-1:0]  crop_width,
    input logic [lir_pkg::DimW-1:0]  crop_height
);

    // the block never refuses a transaction
    `LIR_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")

    // results never exceed the clamp
    `LIR_ASSERT_IMPL(a_clamp, clk, rst_n, done,
        (crop_width <= lir_pkg::DimW'(lir_pkg::MaxDim)) && (crop_height <= lir_pkg::DimW'(lir_pkg::MaxDim)),
        "result above clamp")

    // no result appears in the cycle after leaving reset
    `LIR_ASSERT_NEXT(a_reset_quiet, clk, rst_n, $rose(rst_n), !done, "done after reset")

endmodule

bind largest_inscribed_rect_after_rotation lir_checker u_lir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .crop_width  (crop_width),
    .crop_height (crop_height)
);

@@ dv/largest_inscribed_rect_after_rotation_tb.sv @@
// self-checking bench for the inscribed rectangle block: directed table, then random sweep
// depends on lir_pkg and largest_inscribed_rect_after_rotation
`timescale 1ns / 1ps

module largest_inscribed_rect_after_rotation_tb;

    localparam int       NumRandom  = 1080;
    localparam int       IdleLimit  = 4000;
    localparam int       DrainWait  = lir_pkg::Latency + 20;
    localparam longint   HalfPiQ16  = 102944;
    localparam longint   PiQ16      = 2 * HalfPiQ16;
    localparam longint   OneQ16     = longint'(1) << lir_pkg::FracBits;

    typedef struct {
        logic [lir_pkg::DimW-1:0] w;
        logic [lir_pkg::DimW-1:0] h;
    } crop_t;

    typedef struct {
        logic [lir_pkg::DimW-1:0] h;
        logic [lir_pkg::DimW-1:0] w;
        logic [lir_pkg::AngW-1:0] ang;
        bit                       known;
        logic [lir_pkg::DimW-1:0] exp_w;
        logic [lir_pkg::DimW-1:0] exp_h;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [lir_pkg::DimW-1:0] img_height;
    logic [lir_pkg::DimW-1:0] img_width;
    logic [lir_pkg::AngW-1:0] rot_angle;
    logic                     done;
    logic [lir_pkg::DimW-1:0] crop_width;
    logic [lir_pkg::DimW-1:0] crop_height;

    crop_t     crop_expected[$];
    bit        pending_known;
    crop_t     pending_crop;
    int        mismatches;
    int        accepted;
    int        results;
    int        idle_cycles;
    bit        burst_mode;

    largest_inscribed_rect_after_rotation DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .img_height  (img_height),
        .img_width   (img_width),
        .rot_angle   (rot_angle),
        .done        (done),
        .crop_width  (crop_width),
        .crop_height (crop_height)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // q30 cordic angle table
    function automatic longint arctan_q30(input int i);
        longint t[30];
        t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
              64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
              64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
              64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
              64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
              64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
        return t[i];
    endfunction

    // q30 to q16, round half up and clamp to the unit interval
    function automatic longint unit_round(input longint v);
        longint r;
        r = (v + (longint'(1) << (29 - lir_pkg::FracBits))) >>> (30 - lir_pkg::FracBits);
        if (r < 0)
            r = 0;
        if (r > OneQ16)
            r = OneQ16;
        return r;
    endfunction

    // clip the crop edge to the legal dimension range
    function automatic logic [lir_pkg::DimW-1:0] crop_edge(input longint bb,
                                                           input longint two_y);
        longint v;
        if (bb <= two_y)
            return '0;
        v = (bb - two_y) >>> lir_pkg::FracBits;
        if (v > lir_pkg::MaxDim)
            v = lir_pkg::MaxDim;
        return lir_pkg::DimW'(v);
    endfunction

    // expected crop size for one transaction
    function automatic crop_t predict_crop(input logic [lir_pkg::DimW-1:0] h_in,
                                           input logic [lir_pkg::DimW-1:0] w_in,
                                           input logic [lir_pkg::AngW-1:0] ang_in);
        longint h, w, rem, alpha, cx, cy, cz, dx, dy, cs, sn, bbw, bbh, len, den, y;
        crop_t  r;
        h     = h_in;
        w     = w_in;
        rem   = longint'(ang_in) % PiQ16;
        alpha = (rem < HalfPiQ16) ? rem : PiQ16 - rem;
        cx    = 64'h26DD3B6A;
        cy    = 0;
        cz    = alpha * 16384;
        for (int i = 0; i < lir_pkg::CordicIter; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx -= dx;
                cy += dy;
                cz -= arctan_q30(i);
            end
            else
            begin
                cx += dx;
                cy -= dy;
                cz += arctan_q30(i);
            end
        end
        cs  = unit_round(cx);
        sn  = unit_round(cy);
        bbw = w * cs + h * sn;
        bbh = w * sn + h * cs;
        len = (w < h) ? h : w;
        den = cs + sn;
        y   = (den != 0) ? (len * cs * sn) / den : 0;
        r.w = crop_edge(bbw, 2 * y);
        r.h = crop_edge(bbh, 2 * y);
        return r;
    endfunction

    // record every accepted transaction
    always @(posedge clk)
    begin
        crop_t p;
        if (rst_n && start && !busy)
        begin
            p = predict_crop(img_height, img_width, rot_angle);
            if (pending_known)
                p = pending_crop;
            crop_expected.insert(crop_expected.size(), p);
            accepted++;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        crop_t e;
        if (rst_n && done)
        begin
            results++;
            if (crop_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: w=%0d h=%0d", crop_width, crop_height);
            end
            else
            begin
                e = crop_expected.pop_front();
                if (crop_width !== e.w || crop_height !== e.h)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("crop mismatch: expected w=%0d h=%0d, got w=%0d h=%0d",
                                 e.w, e.h, crop_width, crop_height);
                end
            end
        end
    end

    // watchdog on cycles with no transaction in or out
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drive one transaction and wait until it is taken
    task automatic send_item(input logic [lir_pkg::DimW-1:0] h,
                             input logic [lir_pkg::DimW-1:0] w,
                             input logic [lir_pkg::AngW-1:0] a, input bit known,
                             input crop_t exp_c);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        img_height    <= h;
        img_width     <= w;
        rot_angle     <= a;
        pending_known <= known;
        pending_crop  <= exp_c;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [lir_pkg::DimW-1:0] rand_dim();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return lir_pkg::DimW'($urandom);
        if (sel < 3)
            return lir_pkg::DimW'($urandom_range(1, 64));
        return lir_pkg::DimW'($urandom_range(1, lir_pkg::MaxDim));
    endfunction

    function automatic logic [lir_pkg::AngW-1:0] rand_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return lir_pkg::AngW'($urandom);
        if (sel == 1)
            return lir_pkg::AngW'(HalfPiQ16 * $urandom_range(0, 4) + $urandom_range(0, 8) - 4);
        return lir_pkg::AngW'($urandom_range(0, 411774));
    endfunction

    // stimulus
    initial
    begin
        stim_row_t table_rows[$];
        crop_t     c;
        rst_n         = 1'b0;
        start         = 1'b0;
        img_height    = '0;
        img_width     = '0;
        rot_angle     = '0;
        pending_known = 1'b0;
        pending_crop  = '{default: '0};
        mismatches    = 0;
        accepted      = 0;
        results       = 0;
        idle_cycles   = 0;
        burst_mode    = 1'b0;

        // directed rows: zero sizes, extremes, quadrant folds, wrap past 2*pi
        table_rows = '{
            '{13'd0,    13'd0,    19'd0,      1'b1, 13'd0,    13'd0},
            '{13'd0,    13'd0,    19'd51472,  1'b1, 13'd0,    13'd0},
            '{13'd1,    13'd1,    19'd0,      1'b1, 13'd1,    13'd1},
            '{13'd4096, 13'd4096, 19'd0,      1'b1, 13'd4096, 13'd4096},
            '{13'd100,  13'd200,  19'd0,      1'b1, 13'd200,  13'd100},
            '{13'd100,  13'd200,  19'd205888, 1'b1, 13'd200,  13'd100},
            '{13'd0,    13'd300,  19'd0,      1'b1, 13'd300,  13'd0},
            '{13'd300,  13'd0,    19'd0,      1'b1, 13'd0,    13'd300},
            '{13'd100,  13'd200,  19'd102944, 1'b0, 13'd0,    13'd0},
            '{13'd100,  13'd200,  19'd102943, 1'b0, 13'd0,    13'd0},
            '{13'd100,  13'd200,  19'd308832, 1'b0, 13'd0,    13'd0},
            '{13'd480,  13'd640,  19'd51472,  1'b0, 13'd0,    13'd0},
            '{13'd480,  13'd640,  19'd411774, 1'b0, 13'd0,    13'd0},
            '{13'd480,  13'd640,  19'd411776, 1'b0, 13'd0,    13'd0},
            '{13'd480,  13'd640,  19'h7FFFF,  1'b0, 13'd0,    13'd0},
            '{13'h1FFF, 13'h1FFF, 19'd0,      1'b1, 13'd4096, 13'd4096},
            '{13'h1FFF, 13'd1,    19'd30000,  1'b0, 13'd0,    13'd0},
            '{13'd1,    13'h1FFF, 19'd70000,  1'b0, 13'd0,    13'd0},
            '{13'd4096, 13'd1,    19'd102944, 1'b0, 13'd0,    13'd0},
            '{13'd1,    13'd4096, 19'd150000, 1'b0, 13'd0,    13'd0},
            '{13'h0AAA, 13'h1555, 19'h2AAAA,  1'b0, 13'd0,    13'd0},
            '{13'h1555, 13'h0AAA, 19'h55555,  1'b0, 13'd0,    13'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            c.w = table_rows[i].exp_w;
            c.h = table_rows[i].exp_h;
            send_item(table_rows[i].h, table_rows[i].w, table_rows[i].ang,
                      table_rows[i].known, c);
        end
        pending_known <= 1'b0;

        // random sweep, mixing idle-free bursts and gappy stretches
        c = '{default: '0};
        for (int n = 0; n < NumRandom; n++)
        begin
            if (n % 60 == 0)
                burst_mode = $urandom_range(0, 2) == 0;
            if (n == NumRandom / 2)
            begin
                // let the pipeline drain fully before carrying on
                start <= 1'b0;
                while (crop_expected.size() != 0)
                    @(posedge clk);
            end
            send_item(rand_dim(), rand_dim(), rand_angle(), 1'b0, c);
        end
        start <= 1'b0;

        // drain
        while (crop_expected.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);

        $display("covered %0d transactions and %0d results: zero and oversize dimensions,",
                 accepted, results);
        $display("all four quadrants, wrapped angles, bursts and random gaps");
        if (mismatches == 0 && crop_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
